[design/rsw_pkg.sv]
// Shared types and constants of the reliable sender window.
package rsw_pkg;

	localparam int unsigned SEQ_W    = 32;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned POST_W   = 17;
	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned TMO_W    = 16;
	localparam int unsigned ENTRY_W  = SEQ_W + LEN_W + HANDLE_W + TIME_W;

	localparam logic [POST_W-1:0] HEADER_BYTES  = 17'd18;
	localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd200;
	localparam logic [SEQ_W-1:0]  SEQ_RESET     = 32'd1;

	typedef enum logic [1:0] {
		REQ_SEND = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_TICK = 2'd2,
		REQ_NONE = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		RES_SENT = 3'd0,
		RES_FULL = 3'd1,
		RES_RETX = 3'd2,
		RES_ACK  = 3'd3,
		RES_DONE = 3'd4
	} res_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic do_send;
		logic ack_free;
		logic walk_next;
		logic post_retx;
		logic post_ack;
		logic post_done;
	} rsw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic      in_fire;
		req_kind_t in_kind;
		logic      in_ack_zero;
		logic      walk_end;
		logic      seq_le_ack;
		logic      due;
		logic      out_free;
	} rsw_status_t;

endpackage

[design/rsw_req_if.sv]
// Request channel: one send, acknowledgement or tick request.
interface rsw_req_if;
	import rsw_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [LEN_W-1:0]    frame_len;
	logic [HANDLE_W-1:0] buffer_handle;
	logic [SEQ_W-1:0]    ack_value;
	logic [TIME_W-1:0]   current_time;

	modport source (
		output valid, req_type, frame_len, buffer_handle, ack_value, current_time,
		input  ready
	);

	modport sink (
		input  valid, req_type, frame_len, buffer_handle, ack_value, current_time,
		output ready
	);
endinterface

[design/rsw_rsp_if.sv]
// Result channel: posts, ack reports and tick completion.
interface rsw_rsp_if;
	import rsw_pkg::*;

	logic                valid;
	logic                ready;
	logic [2:0]          result_kind;
	logic [SEQ_W-1:0]    frame_seq;
	logic [POST_W-1:0]   post_length;
	logic [HANDLE_W-1:0] post_handle;
	logic [COUNT_W-1:0]  freed_count;
	logic [COUNT_W-1:0]  in_flight;
	logic                last;

	modport source (
		output valid, result_kind, frame_seq, post_length, post_handle, freed_count,
		       in_flight, last,
		input  ready
	);

	modport sink (
		input  valid, result_kind, frame_seq, post_length, post_handle, freed_count,
		       in_flight, last,
		output ready
	);
endinterface

[design/rsw_ram.sv]
// Generic simple dual-port RAM with registered read.
module rsw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[design/rsw_ctrl.sv]
// Controller state machine: sequences sends, ack walks and tick scans.
module rsw_ctrl
	import rsw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rsw_status_t status,
	output rsw_cmd_t    cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_SEND,
		S_ACK_CHK,
		S_ACK_EV,
		S_ACK_DONE,
		S_TICK_CHK,
		S_TICK_EV,
		S_TICK_POST,
		S_TICK_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (status.in_fire) begin
						unique case (status.in_kind)
							REQ_SEND: state_q <= S_SEND;
							REQ_ACK:  state_q <= status.in_ack_zero ? S_ACK_DONE : S_ACK_CHK;
							REQ_TICK: state_q <= S_TICK_CHK;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_SEND: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				S_ACK_CHK: begin
					state_q <= status.walk_end ? S_ACK_DONE : S_ACK_EV;
				end
				S_ACK_EV: begin
					state_q <= status.seq_le_ack ? S_ACK_CHK : S_ACK_DONE;
				end
				S_ACK_DONE: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				S_TICK_CHK: begin
					state_q <= status.walk_end ? S_TICK_DONE : S_TICK_EV;
				end
				S_TICK_EV: begin
					state_q <= status.due ? S_TICK_POST : S_TICK_CHK;
				end
				S_TICK_POST: begin
					if (status.out_free) state_q <= S_TICK_CHK;
				end
				S_TICK_DONE: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.in_ready  = (state_q == S_IDLE);
		cmd.do_send   = (state_q == S_SEND) && status.out_free;
		cmd.ack_free  = (state_q == S_ACK_EV) && status.seq_le_ack;
		cmd.walk_next = (state_q == S_TICK_EV) && !status.due;
		cmd.post_retx = (state_q == S_TICK_POST) && status.out_free;
		cmd.post_ack  = (state_q == S_ACK_DONE) && status.out_free;
		cmd.post_done = (state_q == S_TICK_DONE) && status.out_free;
	end
endmodule

[design/rsw_dp.sv]
// Datapath: pointers, sequence counter, frame ring and result register.
module rsw_dp
	import rsw_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TMO_W-1:0]   cfg_wdata,
	rsw_req_if.sink            req,
	rsw_rsp_if.source          rsp,
	input  rsw_cmd_t           cmd,
	output rsw_status_t        status
);
	localparam int unsigned PW = $clog2(RING_DEPTH);

	logic [PW-1:0]       wr_ptr_q, rd_ptr_q, walk_ptr_q;
	logic [SEQ_W-1:0]    next_seq_q;
	logic [TMO_W-1:0]    timeout_q;
	logic [COUNT_W-1:0]  freed_q;

	logic [LEN_W-1:0]    plen_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SEQ_W-1:0]    ack_q;
	logic [TIME_W-1:0]   now_q;

	logic                out_valid_q;
	res_kind_t           out_kind_q;
	logic [SEQ_W-1:0]    out_seq_q;
	logic [POST_W-1:0]   out_len_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [COUNT_W-1:0]  out_freed_q;
	logic [COUNT_W-1:0]  out_inflight_q;
	logic                out_last_q;

	logic                post_any;
	res_kind_t           nxt_kind;
	logic [SEQ_W-1:0]    nxt_seq;
	logic [POST_W-1:0]   nxt_len;
	logic [HANDLE_W-1:0] nxt_handle;
	logic [COUNT_W-1:0]  nxt_freed;
	logic [COUNT_W-1:0]  nxt_inflight;
	logic                nxt_last;

	logic                in_fire;
	logic                out_free;
	logic [PW-1:0]       wr_inc, rd_inc, walk_inc;
	logic                full;
	logic [PW:0]         occ;
	logic [COUNT_W-1:0]  occ_now, occ_plus;

	logic                ram_we;
	logic [PW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
	logic [SEQ_W-1:0]    ent_seq;
	logic [LEN_W-1:0]    ent_len;
	logic [HANDLE_W-1:0] ent_handle;
	logic [TIME_W-1:0]   ent_time;
	logic [TIME_W-1:0]   age;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign in_fire  = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = cmd.in_ready;

	assign wr_inc   = ptr_inc(wr_ptr_q);
	assign rd_inc   = ptr_inc(rd_ptr_q);
	assign walk_inc = ptr_inc(walk_ptr_q);
	assign full     = (wr_inc == rd_ptr_q);

	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			occ = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		end else begin
			occ = {1'b0, wr_ptr_q} + (PW+1)'(RING_DEPTH) - {1'b0, rd_ptr_q};
		end
	end
	assign occ_now  = COUNT_W'(occ);
	assign occ_plus = occ_now + COUNT_W'(1);

	assign {ent_seq, ent_len, ent_handle, ent_time} = ram_rdata;
	assign age = now_q - ent_time;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = {next_seq_q, plen_q, handle_q, now_q};
		if (cmd.do_send && !full) begin
			ram_we = 1'b1;
		end else if (cmd.post_retx) begin
			// restamp the entry with the tick time
			ram_we    = 1'b1;
			ram_waddr = walk_ptr_q;
			ram_wdata = {ent_seq, ent_len, ent_handle, now_q};
		end
	end

	rsw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(walk_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			walk_ptr_q <= '0;
			next_seq_q <= SEQ_RESET;
			timeout_q  <= TIMEOUT_RESET;
			freed_q    <= '0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (in_fire) begin
				walk_ptr_q <= rd_ptr_q;
				freed_q    <= '0;
			end
			if (cmd.do_send && !full) begin
				wr_ptr_q   <= wr_inc;
				next_seq_q <= next_seq_q + SEQ_W'(1);
			end
			if (cmd.ack_free) begin
				rd_ptr_q   <= rd_inc;
				walk_ptr_q <= walk_inc;
				freed_q    <= freed_q + COUNT_W'(1);
			end
			if (cmd.walk_next || cmd.post_retx) begin
				walk_ptr_q <= walk_inc;
			end
		end
	end

	// hold the accepted request fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			plen_q   <= req.frame_len;
			handle_q <= req.buffer_handle;
			ack_q    <= req.ack_value;
			now_q    <= req.current_time;
		end
	end

	assign post_any = cmd.do_send || cmd.post_retx || cmd.post_ack || cmd.post_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post_any) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		nxt_kind     = RES_DONE;
		nxt_seq      = '0;
		nxt_len      = '0;
		nxt_handle   = '0;
		nxt_freed    = '0;
		nxt_inflight = occ_now;
		nxt_last     = 1'b1;
		priority if (cmd.do_send && full) begin
			nxt_kind = RES_FULL;
		end else if (cmd.do_send) begin
			nxt_kind     = RES_SENT;
			nxt_seq      = next_seq_q;
			nxt_len      = POST_W'(plen_q) + HEADER_BYTES;
			nxt_handle   = handle_q;
			nxt_inflight = occ_plus;
		end else if (cmd.post_retx) begin
			nxt_kind   = RES_RETX;
			nxt_seq    = ent_seq;
			nxt_len    = POST_W'(ent_len) + HEADER_BYTES;
			nxt_handle = ent_handle;
			nxt_last   = 1'b0;
		end else if (cmd.post_ack) begin
			nxt_kind  = RES_ACK;
			nxt_freed = freed_q;
		end else begin
			nxt_kind = RES_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (post_any) begin
			out_kind_q     <= nxt_kind;
			out_seq_q      <= nxt_seq;
			out_len_q      <= nxt_len;
			out_handle_q   <= nxt_handle;
			out_freed_q    <= nxt_freed;
			out_inflight_q <= nxt_inflight;
			out_last_q     <= nxt_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.frame_seq   = out_seq_q;
	assign rsp.post_length = out_len_q;
	assign rsp.post_handle = out_handle_q;
	assign rsp.freed_count = out_freed_q;
	assign rsp.in_flight   = out_inflight_q;
	assign rsp.last        = out_last_q;

	always_comb begin
		status             = '0;
		status.in_fire     = in_fire;
		status.in_kind     = req_kind_t'(req.req_type);
		status.in_ack_zero = (req.ack_value == '0);
		status.walk_end    = (walk_ptr_q == wr_ptr_q);
		status.seq_le_ack  = (ent_seq <= ack_q);
		status.due         = (age >= TIME_W'(timeout_q));
		status.out_free    = out_free;
	end
endmodule

[design/reliable_sender_window.sv]
// Sender window with a ring of unacknowledged frames and cumulative acks.
//
// Channels: req (send / ack / tick requests) and rsp (results), both valid/ready;
// a request or result moves on a clock edge with valid and ready high.
// cfg_we/cfg_wdata write the retransmit timeout in ms (reset value 200).
// One request is worked at a time; req.ready is high only when idle.
// A send loads its result, a post or ring full, in the S_SEND state once the output
// register is free, then returns to idle for the next request.
// An ack walks the ring from the oldest entry through S_ACK_CHK and S_ACK_EV per freed
// entry, stops at the first uncovered entry or the end, then reports the freed count;
// a zero ack skips the walk and goes straight to the report.
// A tick scans every unacked entry through S_TICK_CHK and S_TICK_EV, posting a retransmit
// from S_TICK_POST for each due entry, and ends with a done result (last high); a full
// ring holds 63 entries.
// The scan speed is set by the single ring RAM read port and its registered read.
// Results sit in an output register, so a stalled receiver holds the pending
// result and the block waits before each post until the register frees up.
// Reset empties the ring, sets the next sequence number to one and the timeout
// to 200; ring contents are not cleared and need no pass after reset.
module reliable_sender_window
	import rsw_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TMO_W-1:0] cfg_wdata,
	rsw_req_if.sink          req,
	rsw_rsp_if.source        rsp
);
	rsw_cmd_t    cmd;
	rsw_status_t status;

	rsw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.cmd   (cmd)
	);

	rsw_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp),
		.cmd      (cmd),
		.status   (status)
	);
endmodule

[test/tb.sv]
// Testbench for reliable_sender_window: queued requests, window model, field-by-field result checks.
module tb;
	import rsw_pkg::*;

	localparam int unsigned DEPTH         = 64;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned MAX_REPORTS   = 50;

	typedef struct {
		req_kind_t           kind;
		logic [LEN_W-1:0]    frame_len;
		logic [HANDLE_W-1:0] handle;
		logic [SEQ_W-1:0]    ack;
		logic [TIME_W-1:0]   now;
	} window_req_t;

	typedef struct {
		res_kind_t           kind;
		logic [SEQ_W-1:0]    seq;
		logic [POST_W-1:0]   length;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  freed;
		logic [COUNT_W-1:0]  in_flight;
		logic                last;
	} window_res_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [TMO_W-1:0] cfg_wdata;

	rsw_req_if req_bus ();
	rsw_rsp_if rsp_bus ();

	reliable_sender_window #(
		.RING_DEPTH (DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	always #5 clk = ~clk;

	// Window model
	logic [SEQ_W-1:0]    win_seq    [DEPTH];
	logic [LEN_W-1:0]    win_len    [DEPTH];
	logic [HANDLE_W-1:0] win_handle [DEPTH];
	logic [TIME_W-1:0]   win_stamp  [DEPTH];
	logic                win_acked  [DEPTH];
	logic [COUNT_W-1:0]  win_head;
	logic [COUNT_W-1:0]  win_tail;
	logic [SEQ_W-1:0]    win_next_seq;
	logic [TMO_W-1:0]    tmo_model;

	window_req_t pending_requests [$];
	window_res_t expected_results [$];
	window_req_t current_req;

	int          error_count = 0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// Stimulus bookkeeping, only roughly tracks the real sequence numbers
	logic [TIME_W-1:0] gen_now;
	logic [SEQ_W-1:0]  gen_sent;
	logic [SEQ_W-1:0]  gen_acked;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < MAX_REPORTS)
			$display("tb: mismatch at %0t: %s got %0h, want %0h", $time, field, got, want);
		error_count++;
	endtask

	function automatic void post_result(input res_kind_t kind, input logic [SEQ_W-1:0] seq,
			input logic [POST_W-1:0] length, input logic [HANDLE_W-1:0] handle,
			input logic [COUNT_W-1:0] freed, input logic last);
		window_res_t r;
		r.kind      = kind;
		r.seq       = seq;
		r.length    = length;
		r.handle    = handle;
		r.freed     = freed;
		r.in_flight = win_tail - win_head;
		r.last      = last;
		expected_results.push_back(r);
	endfunction

	task automatic window_apply(input window_req_t it);
		logic [COUNT_W-1:0] slot;
		logic [COUNT_W-1:0] freed;
		logic [TIME_W-1:0]  age;
		int unsigned        posts;
		case (it.kind)
			REQ_SEND: begin
				if (win_tail + 6'd1 == win_head) begin
					post_result(RES_FULL, '0, '0, '0, '0, 1'b1);
				end else begin
					win_seq[win_tail]    = win_next_seq;
					win_len[win_tail]    = it.frame_len;
					win_handle[win_tail] = it.handle;
					win_stamp[win_tail]  = it.now;
					win_acked[win_tail]  = 1'b0;
					win_tail = win_tail + 6'd1;
					post_result(RES_SENT, win_next_seq, {1'b0, it.frame_len} + HEADER_BYTES,
						it.handle, '0, 1'b1);
					win_next_seq = win_next_seq + 1'b1;
				end
			end
			REQ_ACK: begin
				freed = '0;
				// free from the oldest entry while its sequence is covered
				if (it.ack != '0) begin
					while (win_head != win_tail && win_seq[win_head] <= it.ack) begin
						win_acked[win_head] = 1'b1;
						win_head = win_head + 6'd1;
						freed = freed + 6'd1;
					end
				end
				post_result(RES_ACK, '0, '0, '0, freed, 1'b1);
			end
			REQ_TICK: begin
				slot  = win_head;
				posts = 0;
				while (slot != win_tail && posts < DEPTH - 1) begin
					age = it.now - win_stamp[slot];
					if (!win_acked[slot] && age >= tmo_model) begin
						post_result(RES_RETX, win_seq[slot], {1'b0, win_len[slot]} + HEADER_BYTES,
							win_handle[slot], '0, 1'b0);
						win_stamp[slot] = it.now;
						posts++;
					end
					slot = slot + 6'd1;
				end
				post_result(RES_DONE, '0, '0, '0, '0, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result();
		window_res_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending, kind", 32'(rsp_bus.result_kind), '0);
		end else begin
			want = expected_results.pop_front();
			if (rsp_bus.result_kind !== want.kind)
				report_mismatch("result_kind", 32'(rsp_bus.result_kind), 32'(want.kind));
			if (rsp_bus.frame_seq !== want.seq)
				report_mismatch("frame_seq", rsp_bus.frame_seq, want.seq);
			if (rsp_bus.post_length !== want.length)
				report_mismatch("post_length", 32'(rsp_bus.post_length), 32'(want.length));
			if (rsp_bus.post_handle !== want.handle)
				report_mismatch("post_handle", 32'(rsp_bus.post_handle), 32'(want.handle));
			if (rsp_bus.freed_count !== want.freed)
				report_mismatch("freed_count", 32'(rsp_bus.freed_count), 32'(want.freed));
			if (rsp_bus.in_flight !== want.in_flight)
				report_mismatch("in_flight", 32'(rsp_bus.in_flight), 32'(want.in_flight));
			if (rsp_bus.last !== want.last)
				report_mismatch("last", 32'(rsp_bus.last), 32'(want.last));
		end
	endtask

	function automatic void queue_req(input req_kind_t kind, input logic [LEN_W-1:0] len,
			input logic [HANDLE_W-1:0] handle, input logic [SEQ_W-1:0] ack,
			input logic [TIME_W-1:0] now);
		window_req_t it;
		it.kind      = kind;
		it.frame_len = len;
		it.handle    = handle;
		it.ack       = ack;
		it.now       = now;
		pending_requests.push_back(it);
		if (kind == REQ_SEND)
			gen_sent = gen_sent + 1'b1;
	endfunction

	// Wait until every request is taken and every result is back, then let the block settle
	task automatic drain();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [TMO_W-1:0] value);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tmo_model = value;
		@(negedge clk);
	endtask

	task automatic random_burst(input int count);
		int               issued;
		int unsigned      roll;
		logic [SEQ_W-1:0] ack;
		issued = 0;
		while (issued < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				gen_now = gen_now + $urandom_range(0, tmo_model / 4 + 1);
				queue_req(REQ_SEND, LEN_W'($urandom_range(0, 65535)),
					HANDLE_W'($urandom_range(0, 65535)), $urandom, gen_now);
				issued++;
			end else if (roll < 70) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					ack = '0;
				else if (roll == 1)
					ack = '1;
				else if (roll == 2)
					ack = $urandom;
				else
					ack = gen_acked + $urandom_range(0, gen_sent - gen_acked);
				if (roll >= 3)
					gen_acked = ack;
				else if (roll != 0)
					gen_acked = gen_sent;
				queue_req(REQ_ACK, LEN_W'($urandom_range(0, 65535)),
					HANDLE_W'($urandom_range(0, 65535)), ack, gen_now);
				issued++;
			end else if (roll < 95) begin
				// mostly advance time, now and then jump anywhere
				if ($urandom_range(0, 9) == 0)
					gen_now = $urandom;
				else
					gen_now = gen_now + $urandom_range(0, 2 * tmo_model + 2);
				queue_req(REQ_TICK, LEN_W'($urandom_range(0, 65535)),
					HANDLE_W'($urandom_range(0, 65535)), $urandom, gen_now);
				issued++;
			end else begin
				queue_req(REQ_NONE, LEN_W'($urandom_range(0, 65535)),
					HANDLE_W'($urandom_range(0, 65535)), $urandom, $urandom);
			end
		end
	endtask

	// Driver: present the next request once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				window_apply(current_req);
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					current_req = pending_requests.pop_front();
					req_bus.valid         <= 1'b1;
					req_bus.req_type      <= current_req.kind;
					req_bus.frame_len     <= current_req.frame_len;
					req_bus.buffer_handle <= current_req.handle;
					req_bus.ack_value     <= current_req.ack;
					req_bus.current_time  <= current_req.now;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result, stall the result channel at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready)
				check_result();
			rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		req_bus.valid         = 1'b0;
		req_bus.req_type      = '0;
		req_bus.frame_len     = '0;
		req_bus.buffer_handle = '0;
		req_bus.ack_value     = '0;
		req_bus.current_time  = '0;
		rsp_bus.ready         = 1'b0;
		win_head              = '0;
		win_tail              = '0;
		win_next_seq          = SEQ_RESET;
		tmo_model             = TIMEOUT_RESET;
		gen_now               = '0;
		gen_sent              = '0;
		gen_acked             = '0;
		send_idle_pct         = 14;
		recv_idle_pct         = 52;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timeout: field extremes, aging around the limit, zero ack, ignored type
		queue_req(REQ_SEND, 16'h0000, 16'h0000, '0, 32'd0);
		queue_req(REQ_SEND, 16'hFFFF, 16'hFFFF, '0, 32'hFFFF_FFFF);
		queue_req(REQ_SEND, 16'd1234, 16'h5A5A, '0, 32'd50);
		queue_req(REQ_TICK, '0, '0, '0, 32'd100);
		queue_req(REQ_TICK, '0, '0, '0, 32'd199);
		queue_req(REQ_TICK, '0, '0, '0, 32'd250);
		queue_req(REQ_ACK, '0, '0, 32'd0, 32'd250);
		queue_req(REQ_NONE, '1, '1, '1, '1);
		queue_req(REQ_ACK, '0, '0, 32'd1, 32'd260);
		queue_req(REQ_ACK, '0, '0, 32'd5, 32'd270);
		queue_req(REQ_TICK, '0, '0, '0, 32'h8000_0000);
		queue_req(REQ_ACK, '0, '0, 32'd7, '0);
		queue_req(REQ_SEND, 16'd100, 16'h0001, '0, 32'h0000_1000);

		// zero timeout: resend everything on every tick
		set_timeout(16'd0);
		queue_req(REQ_SEND, 16'd64, 16'h8000, '0, 32'h0000_2000);
		queue_req(REQ_TICK, '0, '0, '0, 32'h0000_2000);
		queue_req(REQ_TICK, '0, '0, '0, 32'h0000_2000);
		queue_req(REQ_ACK, '0, '0, '1, 32'h0000_2000);

		// largest timeout: one short of it, then exactly at it
		set_timeout(16'hFFFF);
		queue_req(REQ_SEND, LEN_W'($urandom_range(0, 65535)),
			HANDLE_W'($urandom_range(0, 65535)), '0, 32'd1000);
		queue_req(REQ_SEND, LEN_W'($urandom_range(0, 65535)),
			HANDLE_W'($urandom_range(0, 65535)), '0, 32'd1000);
		queue_req(REQ_TICK, '0, '0, '0, 32'd66534);
		queue_req(REQ_TICK, '0, '0, '0, 32'd66535);
		queue_req(REQ_ACK, '0, '0, '1, 32'd66535);

		// smallest timeout: fill past full, resend the whole ring, free it in two steps
		set_timeout(16'd1);
		for (int i = 0; i < 65; i++)
			queue_req(REQ_SEND, LEN_W'($urandom_range(0, 65535)),
				HANDLE_W'($urandom_range(0, 65535)), '0, 32'd5000 + i);
		queue_req(REQ_TICK, '0, '0, '0, 32'd10000);
		queue_req(REQ_ACK, '0, '0, 32'd40, 32'd10000);
		queue_req(REQ_TICK, '0, '0, '0, 32'd10000);
		queue_req(REQ_ACK, '0, '0, '1, 32'd10000);
		gen_acked = gen_sent;

		// random traffic across the time wrap, idling swapped
		set_timeout(TMO_W'($urandom_range(1, 1000)));
		send_idle_pct = 52;
		recv_idle_pct = 14;
		gen_now       = 32'hFFFF_F000;
		random_burst(40);

		// random traffic with a random timeout, no idling
		set_timeout(TMO_W'($urandom_range(1, 65535)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_burst(40);

		drain();
		if (expected_results.size() != 0)
			report_mismatch("results never arrived", 32'(expected_results.size()), 0);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
